>>> src/dfs_reverse_postorder_walk_defines.svh
// Assertion macros shared by the walk block's checker.
`ifndef DFS_REVERSE_POSTORDER_WALK_DEFINES_SVH
`define DFS_REVERSE_POSTORDER_WALK_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define DRPW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define DRPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define DRPW_ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/drpw_pkg.sv
// Shared constants and codes for the depth-first walk block.
`timescale 1ns / 1ps
package drpw_pkg;
    localparam int MAX_NODES   = 64;
    localparam int MAX_EDGES   = 256;
    localparam int STACK_DEPTH = 128;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int EDGE_W  = $clog2(MAX_EDGES);
    localparam int STACK_W = $clog2(STACK_DEPTH);
    localparam int ECNT_W  = EDGE_W + 1;
    localparam int OCNT_W  = NODE_W + 1;
    localparam int SP_W    = STACK_W + 1;

    typedef logic [1:0] req_t;
    localparam req_t REQ_ADD     = 2'd0;
    localparam req_t REQ_WALK    = 2'd1;
    localparam req_t REQ_RD_ORD  = 2'd2;
    localparam req_t REQ_RD_BACK = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_DUP   = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;
    localparam status_t STATUS_FULL  = 2'd3;

    typedef logic [1:0] mark_t;
    localparam mark_t MARK_NEW  = 2'd0;
    localparam mark_t MARK_WAIT = 2'd1;
    localparam mark_t MARK_SEEN = 2'd2;
    localparam mark_t MARK_DONE = 2'd3;
endpackage

>>> src/drpw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module drpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/dfs_reverse_postorder_walk.sv
// Edge table with an iterative depth-first walk, reverse post order and back-edge list.
`timescale 1ns / 1ps
// One transaction in gives one transaction out. The block takes one input at a time and
// drops s_tready while it works; a finished result sits in the output register, so the
// next input is taken while that result waits. Add edge: the duplicate scan reads one
// stored edge per cycle through the edge RAM port. Walk: a clearing pass over all 64
// visit marks, then a pop and a pop-data step per stack pop, and for every node expanded
// a read and a check step per stored edge plus a mark step per edge leaving that node;
// the edge RAM read port sets the pace. Users must keep node_count written on the cfg
// channel only between items (not enforced by the block); values above 64 act as 64.
module dfs_reverse_postorder_walk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] edge_source, [11:6] edge_target, [17:12] root_node, [25:18] read_index
    input  logic [31:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [9:2] edge_pos, [15:10] order_node, [22:16] order_count,
    // [31:23] back_edge_count
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    localparam int NW = drpw_pkg::NODE_W;
    localparam int EW = drpw_pkg::EDGE_W;
    localparam int CW = drpw_pkg::ECNT_W;
    localparam int OW = drpw_pkg::OCNT_W;
    localparam int SW = drpw_pkg::STACK_W;
    localparam int PW = drpw_pkg::SP_W;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_ADD_SCAN = 11'b00000000010,
        ST_CLR      = 11'b00000000100,
        ST_INIT     = 11'b00000001000,
        ST_POP      = 11'b00000010000,
        ST_POP_DATA = 11'b00000100000,
        ST_E_RD     = 11'b00001000000,
        ST_E_CHK    = 11'b00010000000,
        ST_E_MARK   = 11'b00100000000,
        ST_RD_WAIT  = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]    node_count_reg;
    logic [OW-1:0] lim;

    drpw_pkg::req_t    req_reg, req_next;
    logic [NW-1:0]     src_reg, src_next, dst_reg, dst_next, root_reg, root_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [EW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]     edge_total_reg, edge_total_next;
    logic [OW-1:0]     post_total_reg, post_total_next;
    logic [CW-1:0]     back_total_reg, back_total_next;
    logic [PW-1:0]     sp_reg, sp_next;
    logic [NW-1:0]     cur_reg, cur_next, tgt_reg, tgt_next;
    logic              over_reg, over_next;
    drpw_pkg::status_t res_status_reg, res_status_next;
    logic [EW-1:0]     res_eidx_reg, res_eidx_next;
    logic [NW-1:0]     res_onode_reg, res_onode_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;

    // RAM ports
    logic               edge_we, stack_we, mark_we, post_we, back_we;
    logic [EW-1:0]      edge_waddr, edge_raddr, back_waddr, back_raddr;
    logic [2*NW-1:0]    edge_wdata, edge_rdata;
    logic [SW-1:0]      stack_waddr, stack_raddr;
    logic [NW:0]        stack_wdata, stack_rdata;
    logic [NW-1:0]      mark_waddr, mark_raddr, post_waddr, post_raddr;
    drpw_pkg::mark_t    mark_wdata, mark_rdata;
    logic [NW-1:0]      post_wdata, post_rdata;
    logic [EW-1:0]      back_wdata, back_rdata;

    logic [NW-1:0]     in_src, in_dst, in_root;
    logic [7:0]        in_ridx;
    logic [OW-1:0]     ord_pos;
    logic [NW-1:0]     e_src, e_tgt, pop_node;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Clamp the node count to the table size.
    assign lim = (node_count_reg > OW'(drpw_pkg::MAX_NODES)) ?
                 OW'(drpw_pkg::MAX_NODES) : OW'(node_count_reg);

    assign in_src  = s_tdata[5:0];
    assign in_dst  = s_tdata[11:6];
    assign in_root = s_tdata[17:12];
    assign in_ridx = s_tdata[25:18];
    assign ord_pos = OW'(post_total_reg - OW'(1) - OW'(in_ridx));
    assign e_src    = edge_rdata[NW-1:0];
    assign e_tgt    = edge_rdata[2*NW-1:NW];
    assign pop_node = stack_rdata[NW:1];

    drpw_ram #(.WIDTH(2*NW), .DEPTH(drpw_pkg::MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata));
    drpw_ram #(.WIDTH(NW+1), .DEPTH(drpw_pkg::STACK_DEPTH)) u_stack_ram (
        .aclk(aclk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .raddr(stack_raddr), .rdata(stack_rdata));
    drpw_ram #(.WIDTH(2), .DEPTH(drpw_pkg::MAX_NODES)) u_mark_ram (
        .aclk(aclk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
        .raddr(mark_raddr), .rdata(mark_rdata));
    drpw_ram #(.WIDTH(NW), .DEPTH(drpw_pkg::MAX_NODES)) u_post_ram (
        .aclk(aclk), .we(post_we), .waddr(post_waddr), .wdata(post_wdata),
        .raddr(post_raddr), .rdata(post_rdata));
    drpw_ram #(.WIDTH(EW), .DEPTH(drpw_pkg::MAX_EDGES)) u_back_ram (
        .aclk(aclk), .we(back_we), .waddr(back_waddr), .wdata(back_wdata),
        .raddr(back_raddr), .rdata(back_rdata));

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        root_next       = root_reg;
        cnt_next        = cnt_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        edge_total_next = edge_total_reg;
        post_total_next = post_total_reg;
        back_total_next = back_total_reg;
        sp_next         = sp_reg;
        cur_next        = cur_reg;
        tgt_next        = tgt_reg;
        over_next       = over_reg;
        res_status_next = res_status_reg;
        res_eidx_next   = res_eidx_reg;
        res_onode_next  = res_onode_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        edge_we = 1'b0; edge_waddr = edge_total_reg[EW-1:0]; edge_wdata = {dst_reg, src_reg};
        edge_raddr = cnt_reg[EW-1:0];
        stack_we = 1'b0; stack_waddr = sp_reg[SW-1:0]; stack_wdata = {pop_node, 1'b1};
        stack_raddr = SW'(sp_reg - PW'(1));
        mark_we = 1'b0; mark_waddr = pop_node; mark_wdata = drpw_pkg::MARK_NEW;
        mark_raddr = e_tgt;
        post_we = 1'b0; post_waddr = post_total_reg[NW-1:0]; post_wdata = pop_node;
        post_raddr = ord_pos[NW-1:0];
        back_we = 1'b0; back_waddr = back_total_reg[EW-1:0]; back_wdata = cnt_reg[EW-1:0];
        back_raddr = in_ridx;

        // Drop the shown result once taken.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next        = s_tuser;
                    src_next        = in_src;
                    dst_next        = in_dst;
                    root_next       = in_root;
                    cnt_next        = '0;
                    cmp_valid_next  = 1'b0;
                    res_status_next = drpw_pkg::STATUS_OK;
                    res_eidx_next   = '0;
                    res_onode_next  = '0;
                    unique case (s_tuser)
                        drpw_pkg::REQ_ADD: begin
                            if (OW'(in_src) >= lim || OW'(in_dst) >= lim) begin
                                res_status_next = drpw_pkg::STATUS_RANGE;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_ADD_SCAN;
                            end
                        end
                        drpw_pkg::REQ_WALK: begin
                            if (OW'(in_root) >= lim) begin
                                res_status_next = drpw_pkg::STATUS_RANGE;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_CLR;
                            end
                        end
                        drpw_pkg::REQ_RD_ORD: begin
                            if (CW'(in_ridx) < CW'(post_total_reg)) begin
                                state_next = ST_RD_WAIT;
                            end else begin
                                res_status_next = drpw_pkg::STATUS_RANGE;
                                state_next      = ST_DONE;
                            end
                        end
                        default: begin
                            if (CW'(in_ridx) < back_total_reg) begin
                                state_next = ST_RD_WAIT;
                            end else begin
                                res_status_next = drpw_pkg::STATUS_RANGE;
                                state_next      = ST_DONE;
                            end
                        end
                    endcase
                end
            end
            ST_ADD_SCAN: begin
                // Compare the edge read last cycle while issuing the next read.
                if (cmp_valid_reg && edge_rdata == {dst_reg, src_reg}) begin
                    res_status_next = drpw_pkg::STATUS_DUP;
                    res_eidx_next   = cmp_idx_reg;
                    cmp_valid_next  = 1'b0;
                    state_next      = ST_DONE;
                end else if (cnt_reg == edge_total_reg) begin
                    cmp_valid_next = 1'b0;
                    if (edge_total_reg >= CW'(drpw_pkg::MAX_EDGES)) begin
                        res_status_next = drpw_pkg::STATUS_FULL;
                    end else begin
                        edge_we         = 1'b1;
                        res_eidx_next   = edge_total_reg[EW-1:0];
                        edge_total_next = CW'(edge_total_reg + CW'(1));
                    end
                    state_next = ST_DONE;
                end else begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = cnt_reg[EW-1:0];
                    cnt_next       = CW'(cnt_reg + CW'(1));
                end
            end
            ST_CLR: begin
                mark_we    = 1'b1;
                mark_waddr = cnt_reg[NW-1:0];
                mark_wdata = drpw_pkg::MARK_NEW;
                cnt_next   = CW'(cnt_reg + CW'(1));
                if (cnt_reg[NW-1:0] == NW'(drpw_pkg::MAX_NODES - 1)) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                mark_we         = 1'b1;
                mark_waddr      = root_reg;
                mark_wdata      = drpw_pkg::MARK_WAIT;
                stack_we        = 1'b1;
                stack_waddr     = '0;
                stack_wdata     = {root_reg, 1'b0};
                sp_next         = PW'(1);
                post_total_next = '0;
                back_total_next = '0;
                over_next       = 1'b0;
                state_next      = ST_POP;
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    res_status_next = over_reg ? drpw_pkg::STATUS_FULL : drpw_pkg::STATUS_OK;
                    state_next      = ST_DONE;
                end else begin
                    sp_next    = PW'(sp_reg - PW'(1));
                    state_next = ST_POP_DATA;
                end
            end
            ST_POP_DATA: begin
                mark_we = 1'b1;
                if (stack_rdata[0]) begin
                    // Post-order marker: append and close the node.
                    if (post_total_reg < OW'(drpw_pkg::MAX_NODES)) begin
                        post_we         = 1'b1;
                        post_total_next = OW'(post_total_reg + OW'(1));
                    end else begin
                        over_next = 1'b1;
                    end
                    mark_wdata = drpw_pkg::MARK_DONE;
                    state_next = ST_POP;
                end else begin
                    if (sp_reg < PW'(drpw_pkg::STACK_DEPTH)) begin
                        stack_we = 1'b1;
                        sp_next  = PW'(sp_reg + PW'(1));
                    end else begin
                        over_next = 1'b1;
                    end
                    mark_wdata = drpw_pkg::MARK_SEEN;
                    cur_next   = pop_node;
                    cnt_next   = '0;
                    state_next = ST_E_RD;
                end
            end
            ST_E_RD: begin
                if (cnt_reg == edge_total_reg) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_E_CHK;
                end
            end
            ST_E_CHK: begin
                if (e_src == cur_reg && OW'(e_tgt) < lim) begin
                    tgt_next   = e_tgt;
                    state_next = ST_E_MARK;
                end else begin
                    cnt_next   = CW'(cnt_reg + CW'(1));
                    state_next = ST_E_RD;
                end
            end
            ST_E_MARK: begin
                case (mark_rdata) inside
                    drpw_pkg::MARK_WAIT, drpw_pkg::MARK_SEEN: begin
                        if (back_total_reg < CW'(drpw_pkg::MAX_EDGES)) begin
                            back_we         = 1'b1;
                            back_total_next = CW'(back_total_reg + CW'(1));
                        end else begin
                            over_next = 1'b1;
                        end
                    end
                    drpw_pkg::MARK_NEW: begin
                        if (sp_reg < PW'(drpw_pkg::STACK_DEPTH)) begin
                            mark_we     = 1'b1;
                            mark_waddr  = tgt_reg;
                            mark_wdata  = drpw_pkg::MARK_WAIT;
                            stack_we    = 1'b1;
                            stack_wdata = {tgt_reg, 1'b0};
                            sp_next     = PW'(sp_reg + PW'(1));
                        end else begin
                            over_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                cnt_next   = CW'(cnt_reg + CW'(1));
                state_next = ST_E_RD;
            end
            ST_RD_WAIT: begin
                if (req_reg == drpw_pkg::REQ_RD_ORD) begin
                    res_onode_next = post_rdata;
                end else begin
                    res_eidx_next = back_rdata;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {back_total_reg, post_total_reg, res_onode_reg,
                                    res_eidx_reg, res_status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= '0;
            edge_total_reg <= '0;
            post_total_reg <= '0;
            back_total_reg <= '0;
            sp_reg         <= '0;
            over_reg       <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_valid) begin
                node_count_reg <= cfg_data;
            end
            edge_total_reg <= edge_total_next;
            post_total_reg <= post_total_next;
            back_total_reg <= back_total_next;
            sp_reg         <= sp_next;
            over_reg       <= over_next;
            cmp_valid_reg  <= cmp_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        root_reg       <= root_next;
        cnt_reg        <= cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        cur_reg        <= cur_next;
        tgt_reg        <= tgt_next;
        res_status_reg <= res_status_next;
        res_eidx_reg   <= res_eidx_next;
        res_onode_reg  <= res_onode_next;
        m_data_reg     <= m_data_next;
    end
endmodule

>>> src/drpw_checker.sv
// Port-level checker for the walk block, bound to the top level.
`timescale 1ns / 1ps
`include "dfs_reverse_postorder_walk_defines.svh"
module drpw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    `DRPW_ASSERT_NEXT_RST(a_rst_no_result, !aresetn, !m_tvalid, "result shown after reset")
    `DRPW_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `DRPW_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "took two inputs")
    `DRPW_ASSERT_SAME(a_order_bound, m_tvalid, m_tdata[22:16] <= 7'd64, "order count too big")
    `DRPW_ASSERT_SAME(a_back_bound, m_tvalid, m_tdata[31:23] <= 9'd256, "back count too big")
endmodule

bind dfs_reverse_postorder_walk drpw_checker u_drpw_checker (.*);
